### design/brle_pkg.sv
package brle_pkg;

  // run length field width inside the engine and the largest run it holds
  localparam int LEN_BITS = 7;
  localparam logic [LEN_BITS-1:0] MAX_LEN = '1;

  // input queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // bit index codes of the back end walker
  localparam logic [3:0] IDX_FIRST = 4'd0;
  localparam logic [3:0] IDX_LAST  = 4'd7;
  localparam logic [3:0] IDX_FLUSH = 4'd8;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } in_word_t;

  typedef struct packed {
    logic       run_bit;
    logic [6:0] run_length;
    logic [7:0] code_byte;
    logic       last_of_item;
    logic       stream_done;
  } out_word_t;

  function automatic out_word_t mk_word(input logic bit_v, input logic [LEN_BITS-1:0] len);
    out_word_t        w;
    logic [LEN_BITS:0] code;
    code           = {bit_v, len};
    w.run_bit      = bit_v;
    w.run_length   = 7'(len);
    w.code_byte    = 8'(code);
    w.last_of_item = 1'b0;
    w.stream_done  = 1'b0;
    return w;
  endfunction

endpackage

### design/bit_run_length_encoder_top.sv
// bit run-length encoder
// input channel: in_valid / in_ready / in_word carries one byte per word plus an
//   end_of_stream flag; bits are taken msb first and runs carry across bytes
// output channel: out_valid / out_ready / out_word carries one run code per word
//   (run bit, run length 1..127, packed code byte, last_of_item, stream_done)
// a run reaching 127 bits is sent at once and the next equal bit opens a new run
// a byte flagged end_of_stream closes the pending run and returns to idle
// throughput: the back end walks one bit per cycle while a byte waits at the
//   queue head and the hold stage can take codes; a final byte that leaves a run
//   open needs one extra flush step
// the hold stage keeps a code until the next code or the end of its byte; an
//   accepted byte is registered in the queue before its first bit is examined
// a two-word input queue lets new bytes arrive while the walker is busy
// a one-code hold stage waits to learn whether a code is the last of its byte,
//   then hands it to the output register
// receiver stall: the output register holds its word, the walker pauses while
//   the hold stage is full and cannot drain, and in_ready drops once the queue fills
// reset (rst_n low, synchronous): queue emptied, no run open, no output pending
module bit_run_length_encoder_top import brle_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);

  // queue head seen by the bit walker
  logic     head_valid;
  in_word_t head_word;
  logic     head_pop;

  brle_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_word    (in_word),
    .head_valid (head_valid),
    .head_word  (head_word),
    .head_pop   (head_pop)
  );

  brle_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_word  (head_word),
    .head_pop   (head_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_word   (out_word)
  );

endmodule

### design/brle_front.sv
module brle_front import brle_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_word_t in_word,
  output logic     head_valid,
  output in_word_t head_word,
  input  logic     head_pop
);

  in_word_t            q_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                push, pop;

  assign in_ready   = (cnt_r != QCNT_W'(QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_word  = q_r[rd_ptr_r];
  assign push       = in_valid && in_ready;
  assign pop        = head_pop && head_valid;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= in_word;
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH))
    else $error("queue count out of range");
`endif

endmodule

### design/brle_back.sv
module brle_back import brle_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      head_valid,
  input  in_word_t  head_word,
  output logic      head_pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);

  logic                cur_bit_r, cur_bit_nxt;
  logic [LEN_BITS-1:0] cur_len_r, cur_len_nxt;
  logic                run_open_r, run_open_nxt;
  logic [3:0]          idx_r, idx_nxt;
  logic                pend_v_r, pend_v_nxt;
  out_word_t           pend_r, pend_nxt;
  logic                out_v_r, out_v_nxt;
  out_word_t           out_r, out_nxt;

  logic                bit_val;
  logic [2:0]          bit_sel;
  logic                out_free, step, gen_v, byte_end, to_flush, mark, pend_move;
  logic                eos;
  out_word_t           gen_w;

  assign eos     = head_word.end_of_stream;
  assign bit_sel = 3'(3'd7 - idx_r[2:0]);
  assign bit_val = head_word.data_byte[bit_sel];

  always_comb begin
    out_free     = !out_v_r || out_ready;
    step         = head_valid && (!pend_v_r || out_free);
    cur_bit_nxt  = cur_bit_r;
    cur_len_nxt  = cur_len_r;
    run_open_nxt = run_open_r;
    gen_v        = 1'b0;
    gen_w        = mk_word(cur_bit_r, cur_len_r);
    byte_end     = 1'b0;
    to_flush     = 1'b0;

    if (idx_r == IDX_FLUSH) begin
      // close the run left open by the final byte
      gen_v        = 1'b1;
      byte_end     = 1'b1;
      cur_bit_nxt  = 1'b0;
      cur_len_nxt  = '0;
      run_open_nxt = 1'b0;
    end else begin
      if (run_open_r && (bit_val != cur_bit_r)) begin
        gen_v       = 1'b1;
        cur_bit_nxt = bit_val;
        cur_len_nxt = LEN_BITS'(1);
      end else if (run_open_r) begin
        cur_len_nxt = cur_len_r + 1'b1;
      end else begin
        run_open_nxt = 1'b1;
        cur_bit_nxt  = bit_val;
        cur_len_nxt  = LEN_BITS'(1);
      end
      // a run at full length goes out at once
      if (cur_len_nxt == MAX_LEN) begin
        gen_v        = 1'b1;
        gen_w        = mk_word(cur_bit_nxt, cur_len_nxt);
        run_open_nxt = 1'b0;
        cur_len_nxt  = '0;
      end
      if (idx_r == IDX_LAST) begin
        if (eos && run_open_nxt) begin
          to_flush = 1'b1;
        end else begin
          byte_end = 1'b1;
          if (eos) begin
            cur_bit_nxt  = 1'b0;
            cur_len_nxt  = '0;
            run_open_nxt = 1'b0;
          end
        end
      end
    end

    if (gen_v && byte_end) begin
      gen_w.last_of_item = 1'b1;
      gen_w.stream_done  = eos;
    end

    if (to_flush) begin
      idx_nxt = IDX_FLUSH;
    end else if (byte_end) begin
      idx_nxt = IDX_FIRST;
    end else begin
      idx_nxt = idx_r + 1'b1;
    end

    mark      = step && byte_end && !gen_v && pend_v_r && !pend_r.last_of_item;
    pend_move = pend_v_r && out_free && (pend_r.last_of_item || (step && gen_v));
    head_pop  = step && byte_end;

    pend_v_nxt = pend_v_r;
    pend_nxt   = pend_r;
    if (pend_move) begin
      pend_v_nxt = 1'b0;
    end
    if (step && gen_v) begin
      pend_v_nxt = 1'b1;
      pend_nxt   = gen_w;
    end else if (mark) begin
      pend_nxt.last_of_item = 1'b1;
      pend_nxt.stream_done  = eos;
    end

    out_v_nxt = out_v_r;
    out_nxt   = out_r;
    if (pend_move) begin
      out_v_nxt = 1'b1;
      out_nxt   = pend_r;
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_bit_r  <= 1'b0;
      cur_len_r  <= '0;
      run_open_r <= 1'b0;
      idx_r      <= IDX_FIRST;
      pend_v_r   <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      if (step) begin
        cur_bit_r  <= cur_bit_nxt;
        cur_len_r  <= cur_len_nxt;
        run_open_r <= run_open_nxt;
        idx_r      <= idx_nxt;
      end
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_v_r;
  assign out_word  = out_r;

`ifndef SYNTHESIS
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= IDX_FLUSH)
    else $error("bit index out of range");
  a_open_len: assert property (@(posedge clk) disable iff (!rst_n)
    run_open_r |-> (cur_len_r != '0) && (cur_len_r != MAX_LEN))
    else $error("open run length out of range");
  a_flush_ctx: assert property (@(posedge clk) disable iff (!rst_n)
    (idx_r == IDX_FLUSH) |-> run_open_r && head_valid && head_word.end_of_stream)
    else $error("flush step without open run at end of stream");
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_v_r && pend_r.stream_done) |-> pend_r.last_of_item)
    else $error("stream end code not marked last");
`endif

endmodule

### tb/sv/run_code_checker.sv
module run_code_checker import brle_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_word_t  in_word,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_word_t out_word,
  output int        fail_count,
  output int        codes_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [6:0] LONGEST_RUN = 7'h7F;
  localparam int         SHOWN_ERRORS = 10;

  out_word_t  expected_codes[$];
  logic       run_active = 1'b0;
  logic       run_bit_q  = 1'b0;
  logic [6:0] run_len_q  = '0;
  int         errors     = 0;

  assign fail_count = errors;

  function automatic void queue_code(input logic b, input logic [6:0] len);
    out_word_t c;
    c.run_bit      = b;
    c.run_length   = len;
    c.code_byte    = {b, len};
    c.last_of_item = 1'b0;
    c.stream_done  = 1'b0;
    expected_codes.push_back(c);
  endfunction

  always @(posedge clk) begin : watch
    out_word_t  exp_code;
    out_word_t  tail;
    logic       b;
    int         i;
    int         depth_before;
    if (!rst_n) begin
      expected_codes.delete();
      run_active = 1'b0;
      run_bit_q  = 1'b0;
      run_len_q  = '0;
    end else begin
      // outgoing code against the oldest prediction
      if (out_valid && out_ready) begin
        if (expected_codes.size() == 0) begin
          errors++;
          if (errors <= SHOWN_ERRORS)
            $display("%t unexpected code: bit %0d len %0d code %02h last %0d done %0d",
                     $realtime, out_word.run_bit, out_word.run_length, out_word.code_byte,
                     out_word.last_of_item, out_word.stream_done);
        end else begin
          exp_code = expected_codes.pop_front();
          if (out_word.run_bit !== exp_code.run_bit ||
              out_word.run_length !== exp_code.run_length ||
              out_word.code_byte !== exp_code.code_byte ||
              out_word.last_of_item !== exp_code.last_of_item ||
              out_word.stream_done !== exp_code.stream_done) begin
            errors++;
            if (errors <= SHOWN_ERRORS)
              $display("%t mismatch: exp %0d/%0d/%02h/%0d/%0d got %0d/%0d/%02h/%0d/%0d",
                       $realtime, exp_code.run_bit, exp_code.run_length,
                       exp_code.code_byte, exp_code.last_of_item, exp_code.stream_done,
                       out_word.run_bit, out_word.run_length, out_word.code_byte,
                       out_word.last_of_item, out_word.stream_done);
          end
        end
      end

      // accepted byte: walk its bits msb first
      if (in_valid && in_ready) begin
        depth_before = expected_codes.size();
        for (i = 7; i >= 0; i--) begin
          b = in_word.data_byte[i];
          if (run_active && b != run_bit_q) begin
            queue_code(run_bit_q, run_len_q);
            run_bit_q = b;
            run_len_q = 7'd1;
          end else if (run_active) begin
            run_len_q = run_len_q + 7'd1;
          end else begin
            run_active = 1'b1;
            run_bit_q  = b;
            run_len_q  = 7'd1;
          end
          // full run goes out at once, next equal bit opens a fresh one
          if (run_len_q == LONGEST_RUN) begin
            queue_code(run_bit_q, run_len_q);
            run_active = 1'b0;
            run_len_q  = '0;
          end
        end
        if (in_word.end_of_stream) begin
          if (run_active)
            queue_code(run_bit_q, run_len_q);
          run_active = 1'b0;
          run_bit_q  = 1'b0;
          run_len_q  = '0;
        end
        if (expected_codes.size() > depth_before) begin
          tail              = expected_codes.pop_back();
          tail.last_of_item = 1'b1;
          tail.stream_done  = in_word.end_of_stream;
          expected_codes.push_back(tail);
        end
      end
    end
    codes_pending <= expected_codes.size();
  end

endmodule

### tb/sv/bit_run_length_encoder_top_tb.sv
module bit_run_length_encoder_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import brle_pkg::*;

  // size of the random part and the one long receiver hold-off
  localparam int RANDOM_WORDS = 225;
  localparam int LONG_HOLD    = 300;

  typedef enum int {
    STREAM_NOISE,   // random bytes, end flag may fall anywhere
    STREAM_SPARSE,  // mostly solid bytes with the odd flipped bit
    STREAM_SOLID    // long solid stretch, can cross the 127 bit limit
  } stream_kind_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_word;

  int   fail_count;
  int   codes_pending;

  // idle percentages; the sender one lives in the stimulus process only
  int   send_idle_pct = 22;
  int   recv_idle_pct = 60;
  logic hold_off_req  = 1'b0;

  always #5 clk = ~clk;

  bit_run_length_encoder_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  run_code_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_word       (in_word),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_word      (out_word),
    .fail_count    (fail_count),
    .codes_pending (codes_pending)
  );

  // offer one word and hold it until the block takes it
  task automatic push_byte(input logic [7:0] data, input logic eos);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid              <= 1'b1;
    in_word.data_byte     <= data;
    in_word.end_of_stream <= eos;
    do @(posedge clk); while (!in_ready);
  endtask

  // one stream of random shape; the final word always closes it
  task automatic send_stream(input stream_kind_t kind, input int nbytes);
    logic [7:0] solid;
    logic [7:0] data;
    logic       eos;
    int         k;
    solid = {8{1'($urandom_range(0, 1))}};
    for (k = 0; k < nbytes; k++) begin
      eos = (k == nbytes - 1);
      case (kind)
        STREAM_NOISE: begin
          data = 8'($urandom);
          if ($urandom_range(0, 7) == 0)
            eos = 1'b1;
        end
        STREAM_SPARSE: begin
          if ($urandom_range(0, 99) < 70)
            data = {8{1'($urandom_range(0, 1))}};
          else
            data = {8{1'($urandom_range(0, 1))}} ^ (8'h01 << $urandom_range(0, 7));
        end
        default: begin
          data = eos ? 8'($urandom) : solid;
        end
      endcase
      push_byte(data, eos);
    end
  endtask

  // receiver: random stalls, plus one long hold-off so the input backs up
  initial begin : receiver
    int hold_left;
    logic hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (hold_off_req && !hold_done) begin
        out_ready <= 1'b0;
        hold_left = LONG_HOLD - 1;
        hold_done = 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  initial begin : stimulus
    int           sent;
    int           phase;
    int           nbytes;
    int           pick;
    int           k;
    stream_kind_t kind;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: single-run bytes, an all-alternating byte, a two-run byte
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b1);
    push_byte(8'hAA, 1'b1);
    push_byte(8'h0F, 1'b1);
    // open zero run carried in, then alternating: nine codes from one word
    push_byte(8'h00, 1'b0);
    push_byte(8'hAA, 1'b1);
    push_byte(8'h55, 1'b0);
    // zero run of seven, then fifteen zero bytes: 127 exactly on the final
    // word, so the end flag has nothing left to flush
    push_byte(8'h80, 1'b0);
    for (k = 0; k < 15; k++)
      push_byte(8'h00, k == 14);

    // random streams in three idling phases
    sent = 0;
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 22;
          recv_idle_pct <= 60;
        end
        1: begin
          send_idle_pct = 60;
          recv_idle_pct <= 22;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct <= 0;
          hold_off_req  <= 1'b1;
        end
      endcase
      while (sent < (phase + 1) * RANDOM_WORDS / 3) begin
        pick = $urandom_range(0, 9);
        if (pick < 3) begin
          kind   = STREAM_NOISE;
          nbytes = $urandom_range(1, 8);
        end else if (pick < 8) begin
          kind   = STREAM_SPARSE;
          nbytes = $urandom_range(2, 12);
        end else begin
          kind   = STREAM_SOLID;
          nbytes = $urandom_range(14, 34);
        end
        send_stream(kind, nbytes);
        sent += nbytes;
      end
    end
    in_valid <= 1'b0;

    // drain, then leave room for any stray code
    do @(posedge clk); while (codes_pending != 0);
    repeat (12) @(posedge clk);

    if (fail_count == 0 && codes_pending == 0)
      $display("PASS bit_run_length_encoder_top");
    else
      $display("FAIL bit_run_length_encoder_top");
    $finish;
  end

  // run limit, far beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("FAIL bit_run_length_encoder_top");
    $finish;
  end

endmodule
